[src/command_source_priority_arbiter_macros.svh]
// Assertion macros for the command source priority arbiter.
// Used by the top level only; no other dependencies.
`ifndef COMMAND_SOURCE_PRIORITY_ARBITER_MACROS_SVH
`define COMMAND_SOURCE_PRIORITY_ARBITER_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define CSPA_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define CSPA_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

[src/cspa_pkg.sv]
// Package for the command source priority arbiter: widths, reason codes, state codes.
// No dependencies.
package cspa_pkg;
   localparam int MaxSources = 8;
   localparam int DefSources = 4;
   localparam int IdxW       = 3;
   localparam int NumW       = 4;
   localparam int CsrIdxW    = 2;
   localparam int ReqW       = 72;
   localparam int RspW       = 120;

   typedef enum logic [2:0] {
      RSN_NONE     = 3'd0,
      RSN_RELEASED = 3'd1,
      RSN_STALE    = 3'd2,
      RSN_HANDOVER = 3'd3,
      RSN_INVALID  = 3'd4
   } reason_type;

   typedef enum logic [1:0] {
      CSR_ENABLE   = 2'd0,
      CSR_RANKS    = 2'd1,
      CSR_TMO_LOW  = 2'd2,
      CSR_TMO_HIGH = 2'd3
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SAMPLE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DECIDE = 5'b01000,
      ST_OUT    = 5'b10000
   } state_type;

   localparam logic [7:0]  EnableReset = 8'd15;
   localparam logic [23:0] RanksReset  = 24'd1672;
endpackage

[src/cspa_stale_unit.sv]
// Shared staleness compare: elapsed ticks against a 16-bit timeout.
// Depends on cspa_pkg.
module cspa_stale_unit (
   input  logic [31:0] now_ticks,
   input  logic [31:0] receipt,
   input  logic [15:0] timeout,
   output logic        fresh
);
   import cspa_pkg::*;
   logic [31:0] elapsed;
   // Wrap the difference, then compare
   assign elapsed = now_ticks - receipt;
   assign fresh   = elapsed <= {16'd0, timeout};
endmodule

[src/command_source_priority_arbiter.sv]
// Command source priority arbiter: request/response streams and a register write port.
// Depends on cspa_pkg, cspa_stale_unit and the assertion macro header.
//
// Usage: req_tdata carries one transaction: a sample (req_tuser 0) or an
// evaluate (req_tuser 1). Each transaction gives exactly one rsp transaction
// holding a snapshot of the arbitration state after the operation.
// csr_* writes enable, ranks and two timeout words; write only while idle.
// A sample passes through SAMPLE and then OUT, which loads the response
// register; an evaluate passes through SCAN, DECIDE and OUT, the scan visiting
// one source per cycle through a single stale compare and rank compare.
// A new transaction is taken only after the previous response is taken.
// req_tready is low while a transaction is in work and while a response
// waits for rsp_tready, so a stalled receiver holds the response and stops
// intake; nothing is dropped.
// Reset: synchronous, active high; clears all source state, counters and
// selection and restores enable 15, ranks 1672, timeouts 0.
`include "command_source_priority_arbiter_macros.svh"
module command_source_priority_arbiter #(
   parameter int NUM_SOURCES = cspa_pkg::DefSources
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // source_number[3:0], sequence_req[35:4], active[36], valid_req[37],
   // now_ticks[69:38], zero fill [71:70]
   input  logic [cspa_pkg::ReqW-1:0]   req_tdata,
   // kind
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // accepted[0], change_count[32:1], sel_present[33], selected_source[37:34],
   // previous_source[41:38], reason[44:42], preempted[45], selected_sequence[77:46],
   // selected_activation_epoch[109:78], quarantined_mask[117:110],
   // all_released[118], zero fill [119]
   output logic [cspa_pkg::RspW-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [cspa_pkg::CsrIdxW-1:0] csr_index,
   input  logic [63:0]                 csr_data
);
   import cspa_pkg::*;

   localparam int N = NUM_SOURCES;

   state_type state_ff, state_in;
   logic [7:0]  enable_ff;
   logic [23:0] ranks_ff;
   logic [63:0] tmo_lo_ff, tmo_hi_ff;

   logic [31:0] receipt_ff [MaxSources];
   logic [31:0] lastseq_ff [MaxSources];
   logic [31:0] actep_ff   [MaxSources];
   reason_type  loss_ff    [MaxSources];
   logic [MaxSources-1:0] active_ff, quar_ff, relseen_ff, known_ff;

   logic [NumW-1:0] cur_ff, prior_ff;
   logic [31:0] selcnt_ff, actcnt_ff, epsel_ff;
   reason_type  pend_ff, trans_ff;
   logic        pre_ff;

   // latched transaction
   logic        kind_ff, act_ff, vld_ff, acc_ff;
   logic [NumW-1:0] num_ff;
   logic [31:0] seq_ff, now_ff;

   // scan
   logic [IdxW:0]  scan_ff;
   logic           best_ok_ff;
   logic [IdxW-1:0] best_ff;

   logic [RspW-1:0] rsp_ff;
   logic            rsp_v_ff;

   logic req_fire;
   assign req_tready = state_ff == ST_IDLE && !rsp_v_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_ff;

   function automatic logic [2:0] rank_of(input logic [23:0] r, input logic [IdxW-1:0] i);
      rank_of = r[3*i +: 3];
   endfunction

   function automatic logic [15:0] tmo_of(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [IdxW-1:0] i);
      logic [63:0] w;
      w = i[2] ? hi : lo;
      tmo_of = w[16*i[1:0] +: 16];
   endfunction

   // Scan element
   logic [IdxW-1:0] si;
   logic fresh, sc_cand;
   assign si = scan_ff[IdxW-1:0];
   cspa_stale_unit u_stale (
      .now_ticks(now_ff), .receipt(receipt_ff[si]),
      .timeout(tmo_of(tmo_lo_ff, tmo_hi_ff, si)), .fresh(fresh)
   );
   assign sc_cand = enable_ff[si] && active_ff[si] && !quar_ff[si] && relseen_ff[si];

   // Sample index
   logic [IdxW-1:0] ni;
   logic num_ok;
   assign ni = IdxW'(num_ff - NumW'(1));
   assign num_ok = num_ff >= NumW'(1) && num_ff <= NumW'(N) && enable_ff[ni];

   // Decide
   logic [NumW-1:0] next_sel;
   logic prev_ok, pre_c;
   logic [IdxW-1:0] pi;
   reason_type why;
   assign next_sel = best_ok_ff ? NumW'(best_ff) + NumW'(1) : '0;
   assign prev_ok  = cur_ff >= NumW'(1) && cur_ff <= NumW'(N);
   assign pi       = IdxW'(cur_ff - NumW'(1));
   assign pre_c    = prev_ok && best_ok_ff &&
                     rank_of(ranks_ff, best_ff) > rank_of(ranks_ff, pi) &&
                     actep_ff[best_ff] > epsel_ff;
   always_comb begin
      if (pre_c) why = RSN_HANDOVER;
      else if (pend_ff != RSN_NONE) why = pend_ff;
      else if (prev_ok && loss_ff[pi] != RSN_NONE) why = loss_ff[pi];
      else why = RSN_NONE;
   end

   // Snapshot
   logic [7:0] qmask;
   logic all_rel, has;
   logic [IdxW-1:0] ci;
   always_comb begin
      qmask = '0;
      all_rel = 1'b1;
      for (int k = 0; k < N; k++) begin
         qmask[k] = quar_ff[k];
         if (enable_ff[k] && !(relseen_ff[k] && !active_ff[k] && !quar_ff[k]))
            all_rel = 1'b0;
      end
   end
   assign has = prev_ok;
   assign ci  = pi;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_fire) state_in = req_tuser ? ST_SCAN : ST_SAMPLE;
         ST_SAMPLE: state_in = ST_OUT;
         ST_SCAN:   if (scan_ff == (IdxW+1)'(N-1)) state_in = ST_DECIDE;
         ST_DECIDE: state_in = ST_OUT;
         ST_OUT:    state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         enable_ff <= EnableReset;
         ranks_ff <= RanksReset;
         tmo_lo_ff <= '0;
         tmo_hi_ff <= '0;
         for (int k = 0; k < MaxSources; k++) begin
            receipt_ff[k] <= '0;
            lastseq_ff[k] <= '0;
            actep_ff[k] <= '0;
            loss_ff[k] <= RSN_NONE;
         end
         active_ff <= '0; quar_ff <= '0; relseen_ff <= '0; known_ff <= '0;
         cur_ff <= '0; prior_ff <= '0;
         selcnt_ff <= '0; actcnt_ff <= '0; epsel_ff <= '0;
         pend_ff <= RSN_NONE; trans_ff <= RSN_NONE; pre_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         acc_ff <= 1'b0;
         scan_ff <= '0; best_ok_ff <= 1'b0; best_ff <= '0;
      end else begin
         state_ff <= state_in;
         // register writes
         if (csr_valid) begin
            case (csr_index)
               CSR_ENABLE:   enable_ff <= csr_data[7:0];
               CSR_RANKS:    ranks_ff  <= csr_data[23:0];
               CSR_TMO_LOW:  tmo_lo_ff <= csr_data;
               CSR_TMO_HIGH: tmo_hi_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_v_ff && rsp_tready) rsp_v_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  kind_ff <= req_tuser;
                  num_ff  <= req_tdata[3:0];
                  seq_ff  <= req_tdata[35:4];
                  act_ff  <= req_tdata[36];
                  vld_ff  <= req_tdata[37];
                  now_ff  <= req_tdata[69:38];
                  acc_ff  <= 1'b0;
                  scan_ff <= '0;
                  best_ok_ff <= 1'b0;
               end
            end
            ST_SAMPLE: begin
               if (num_ok) begin
                  receipt_ff[ni] <= now_ff;
                  if (!vld_ff || (act_ff && (!relseen_ff[ni] || quar_ff[ni] ||
                      !(!known_ff[ni] || seq_ff > lastseq_ff[ni])))) begin
                     active_ff[ni] <= 1'b0; quar_ff[ni] <= 1'b1;
                     relseen_ff[ni] <= 1'b0; loss_ff[ni] <= RSN_INVALID;
                     if (cur_ff == num_ff) pend_ff <= RSN_INVALID;
                  end else if (!act_ff) begin
                     active_ff[ni] <= 1'b0; quar_ff[ni] <= 1'b0;
                     relseen_ff[ni] <= 1'b1; known_ff[ni] <= 1'b1;
                     lastseq_ff[ni] <= seq_ff; loss_ff[ni] <= RSN_RELEASED;
                     if (cur_ff == num_ff) pend_ff <= RSN_RELEASED;
                     acc_ff <= 1'b1;
                  end else begin
                     active_ff[ni] <= 1'b1; known_ff[ni] <= 1'b1;
                     lastseq_ff[ni] <= seq_ff; loss_ff[ni] <= RSN_NONE;
                     acc_ff <= 1'b1;
                     if (!active_ff[ni]) begin
                        actcnt_ff <= actcnt_ff + 32'd1;
                        actep_ff[ni] <= actcnt_ff + 32'd1;
                     end
                  end
               end
            end
            ST_SCAN: begin
               scan_ff <= scan_ff + 1'b1;
               if (sc_cand) begin
                  if (fresh) begin
                     if (!best_ok_ff || rank_of(ranks_ff, si) > rank_of(ranks_ff, best_ff)) begin
                        best_ok_ff <= 1'b1;
                        best_ff <= si;
                     end
                  end else begin
                     active_ff[si] <= 1'b0; quar_ff[si] <= 1'b1;
                     relseen_ff[si] <= 1'b0; loss_ff[si] <= RSN_STALE;
                     if (cur_ff == NumW'(si) + NumW'(1)) pend_ff <= RSN_STALE;
                  end
               end
            end
            ST_DECIDE: begin
               if (next_sel != cur_ff) begin
                  selcnt_ff <= selcnt_ff + 32'd1;
                  cur_ff <= next_sel;
                  epsel_ff <= actcnt_ff;
                  pend_ff <= RSN_NONE;
                  prior_ff <= cur_ff;
                  trans_ff <= why;
                  pre_ff <= pre_c;
               end
            end
            ST_OUT: begin
               rsp_v_ff <= 1'b1;
               rsp_ff <= {1'b0, all_rel, qmask,
                          has ? actep_ff[ci] : 32'd0,
                          has ? lastseq_ff[ci] : 32'd0,
                          pre_ff, trans_ff, prior_ff,
                          has ? cur_ff : NumW'(0), has, selcnt_ff, acc_ff};
            end
            default: ;
         endcase
      end
   end

   `CSPA_ASSERT_IMP(a_no_accept_busy, clock, reset, rsp_tvalid, !req_tready, "accept while busy")
   `CSPA_ASSERT_NEXT(a_out_to_rsp, clock, reset, state_ff == ST_OUT, rsp_tvalid, "no response")
   `CSPA_ASSERT_IMP(a_eval_no_accept, clock, reset, rsp_tvalid && rsp_tdata[0], !kind_ff, "bad accept")
endmodule

[tb/tb_command_source_priority_arbiter.sv]
// Testbench for the command source priority arbiter: random and directed samples and
// evaluates, checked against a behavioral predictor. Depends on cspa_pkg and the RTL.
`timescale 1ns / 1ps
module tb_command_source_priority_arbiter;
   import cspa_pkg::*;

   localparam int NSRC = 4;

   typedef struct packed {
      logic        kind;
      logic [3:0]  num;
      logic [31:0] seq;
      logic        act;
      logic        ok;
      logic [31:0] now;
   } cmd_type;

   // declared from the highest bit down, so accepted lands in bit 0
   typedef struct packed {
      logic        all_rel;
      logic [7:0]  qmask;
      logic [31:0] sel_act;
      logic [31:0] sel_seq;
      logic        preempted;
      logic [2:0]  reason;
      logic [3:0]  prev;
      logic [3:0]  sel;
      logic        has_sel;
      logic [31:0] epoch;
      logic        accepted;
   } snap_type;

   logic clock, reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [ReqW-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RspW-1:0] rsp_tdata;
   logic csr_valid, csr_ready;
   logic [CsrIdxW-1:0] csr_index;
   logic [63:0] csr_data;

   command_source_priority_arbiter #(.NUM_SOURCES(NSRC)) dut (.*);

   // predictor copy of the arbitration state
   logic [7:0]  m_enable;
   logic [23:0] m_ranks;
   logic [63:0] m_tmo_lo, m_tmo_hi;
   logic [31:0] rx_time [NSRC];
   logic        s_active [NSRC], s_quar [NSRC], s_released [NSRC], s_seq_known [NSRC];
   logic [31:0] s_last_seq [NSRC], s_act_epoch [NSRC];
   reason_type  s_loss [NSRC];
   logic [3:0]  cur_sel, prior_sel;
   logic [31:0] sel_count, act_count, epoch_at_sel;
   reason_type  pend_reason, trans_reason;
   logic        trans_pre;

   cmd_type  cmd_queue [$];
   snap_type snap_queue [$];
   int    errors = 0, n_rsp = 0, n_acc = 0, n_changes = 0;

   function automatic logic [2:0] rank_of(int i);
      return m_ranks[3*i +: 3];
   endfunction

   function automatic logic [15:0] timeout_of(int i);
      return m_tmo_lo[16*i +: 16];
   endfunction

   task automatic clear_model();
      m_enable = EnableReset;
      m_ranks  = RanksReset;
      m_tmo_lo = '0;
      m_tmo_hi = '0;
      for (int i = 0; i < NSRC; i++) begin
         rx_time[i] = 0; s_active[i] = 0; s_quar[i] = 0; s_released[i] = 0;
         s_seq_known[i] = 0; s_last_seq[i] = 0; s_act_epoch[i] = 0; s_loss[i] = RSN_NONE;
      end
      cur_sel = 0; prior_sel = 0; sel_count = 0; act_count = 0; epoch_at_sel = 0;
      pend_reason = RSN_NONE; trans_reason = RSN_NONE; trans_pre = 0;
   endtask

   function automatic void drop_source(int i, reason_type code);
      s_active[i] = 0; s_quar[i] = 1; s_released[i] = 0; s_loss[i] = code;
      if (cur_sel == i + 1) pend_reason = code;
   endfunction

   function automatic logic apply_sample(cmd_type c);
      int i;
      logic adv;
      if (c.num < 1 || c.num > NSRC) return 0;
      i = c.num - 1;
      if (!m_enable[i]) return 0;
      rx_time[i] = c.now;
      if (!c.ok) begin
         drop_source(i, RSN_INVALID);
         return 0;
      end
      if (!c.act) begin
         s_active[i] = 0; s_quar[i] = 0; s_released[i] = 1; s_seq_known[i] = 1;
         s_last_seq[i] = c.seq; s_loss[i] = RSN_RELEASED;
         if (cur_sel == c.num) pend_reason = RSN_RELEASED;
         return 1;
      end
      adv = !s_seq_known[i] || c.seq > s_last_seq[i];
      if (!s_released[i] || s_quar[i] || !adv) begin
         drop_source(i, RSN_INVALID);
         return 0;
      end
      if (!s_active[i]) begin
         act_count++;
         s_act_epoch[i] = act_count;
      end
      s_active[i] = 1; s_seq_known[i] = 1; s_last_seq[i] = c.seq; s_loss[i] = RSN_NONE;
      return 1;
   endfunction

   function automatic void apply_evaluate(logic [31:0] now);
      int best = -1;
      logic elig, pre;
      logic [3:0] nxt, prv;
      reason_type why;
      for (int i = 0; i < NSRC; i++) begin
         elig = m_enable[i] && s_active[i] && !s_quar[i] && s_released[i];
         if (elig && (now - rx_time[i]) > {16'd0, timeout_of(i)}) begin
            drop_source(i, RSN_STALE);
            elig = 0;
         end
         if (elig && (best < 0 || rank_of(i) > rank_of(best))) best = i;
      end
      nxt = (best < 0) ? 4'd0 : 4'(best + 1);
      prv = cur_sel;
      if (nxt != prv) begin
         pre = prv >= 1 && prv <= NSRC && best >= 0 && rank_of(best) > rank_of(prv - 1)
               && s_act_epoch[best] > epoch_at_sel;
         why = RSN_NONE;
         if (pre) why = RSN_HANDOVER;
         else if (pend_reason != RSN_NONE) why = pend_reason;
         else if (prv >= 1 && prv <= NSRC && s_loss[prv - 1] != RSN_NONE) why = s_loss[prv - 1];
         sel_count++;
         cur_sel = nxt; epoch_at_sel = act_count; pend_reason = RSN_NONE;
         prior_sel = prv; trans_reason = why; trans_pre = pre;
         n_changes++;
      end
   endfunction

   function automatic snap_type predict_snapshot(cmd_type c);
      snap_type s;
      logic acc = 0;
      logic has;
      if (!c.kind) acc = apply_sample(c);
      else apply_evaluate(c.now);
      has = cur_sel >= 1 && cur_sel <= NSRC;
      s = '0;
      s.accepted = acc;
      s.epoch = sel_count;
      s.has_sel = has;
      s.sel = has ? cur_sel : 4'd0;
      s.prev = prior_sel;
      s.reason = trans_reason;
      s.preempted = trans_pre;
      s.sel_seq = has ? s_last_seq[cur_sel - 1] : 32'd0;
      s.sel_act = has ? s_act_epoch[cur_sel - 1] : 32'd0;
      s.all_rel = 1;
      for (int i = 0; i < NSRC; i++) begin
         s.qmask[i] = s_quar[i];
         if (m_enable[i] && !(s_released[i] && !s_active[i] && !s_quar[i])) s.all_rel = 0;
      end
      return s;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // driver: present queued commands with random gaps
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         gap_left = $urandom_range(0, 7);
      end else if (req_tvalid && req_tready) begin
         snap_queue = {snap_queue, predict_snapshot(cmd_queue.pop_front())};
         req_tvalid <= 0;
         gap_left = $urandom_range(0, 7);
      end else if (!req_tvalid) begin
         if (gap_left > 0) gap_left--;
         else if (cmd_queue.size() > 0) begin
            req_tvalid <= 1;
            req_tuser  <= cmd_queue[0].kind;
            req_tdata  <= {2'b00, cmd_queue[0].now, cmd_queue[0].ok, cmd_queue[0].act,
                           cmd_queue[0].seq, cmd_queue[0].num};
         end
      end
   end

   // monitor: compare each response with the oldest prediction
   int stall_left = 0;
   always @(posedge clock) begin
      snap_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = snap_type'(rsp_tdata[118:0]);
            n_rsp++;
            if (snap_queue.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected: %h", $time, got);
            end else begin
               want = snap_queue.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: mismatch expected %h actual %h", $time, want, got);
               end
               if (want.accepted) n_acc++;
            end
            stall_left = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) stall_left = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 0;
         end else rsp_tready <= 1;
      end
   end

   task automatic wait_idle();
      while (cmd_queue.size() > 0 || req_tvalid || snap_queue.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
      case (idx)
         CSR_ENABLE:   m_enable = val[7:0];
         CSR_RANKS:    m_ranks  = val[23:0];
         CSR_TMO_LOW:  m_tmo_lo = val;
         CSR_TMO_HIGH: m_tmo_hi = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic queue_cmd(logic kind, logic [3:0] num, logic [31:0] seq, logic act,
                            logic ok, logic [31:0] now);
      cmd_type c;
      c.kind = kind; c.num = num; c.seq = seq; c.act = act; c.ok = ok; c.now = now;
      cmd_queue = {cmd_queue, c};
   endtask

   // one phase of random traffic: mostly well-formed release/activate sessions
   logic [31:0] clk_now;
   logic [31:0] seq_of [NSRC];
   task automatic random_phase(int count);
      int s, r;
      for (int k = 0; k < count; k++) begin
         clk_now += $urandom_range(0, 40);
         if ($urandom_range(0, 15) == 0) clk_now = $urandom;
         s = $urandom_range(0, NSRC - 1);
         r = $urandom_range(0, 99);
         if (r < 30)
            queue_cmd(1, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), clk_now);
         else if (r < 45) begin
            seq_of[s] = $urandom_range(0, 3) == 0 ? $urandom : seq_of[s] + 1;
            queue_cmd(0, 4'(s + 1), seq_of[s], 0, 1, clk_now);
         end else if (r < 85) begin
            seq_of[s] += $urandom_range(1, 3);
            queue_cmd(0, 4'(s + 1), seq_of[s], 1, 1, clk_now);
         end else if (r < 92)
            queue_cmd(0, 4'(s + 1), $urandom, 1'($urandom), 1'($urandom), clk_now);
         else
            queue_cmd(0, 4'($urandom), $urandom, 1'($urandom), 1'($urandom), $urandom);
      end
      wait_idle();
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      rsp_tready = 0;
      csr_valid = 0; csr_index = CSR_ENABLE; csr_data = '0;
      clear_model();
      clk_now = 0;
      for (int i = 0; i < NSRC; i++) seq_of[i] = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: zero timeouts, releases, activation, preemption, loss, bad numbers
      queue_cmd(1, 0, 0, 0, 0, 0);
      queue_cmd(0, 0, 5, 1, 1, 0);
      queue_cmd(0, 15, 5, 1, 1, 0);
      queue_cmd(0, 1, 5, 1, 1, 0);
      queue_cmd(0, 1, 0, 0, 1, 100);
      queue_cmd(0, 2, 32'hFFFF_FFFF, 0, 1, 100);
      queue_cmd(0, 1, 1, 1, 1, 100);
      queue_cmd(1, 0, 0, 0, 0, 100);
      queue_cmd(0, 2, 0, 1, 1, 100);
      queue_cmd(0, 3, 9, 0, 1, 100);
      queue_cmd(0, 3, 10, 1, 1, 100);
      queue_cmd(1, 0, 0, 0, 0, 100);
      queue_cmd(0, 3, 10, 1, 1, 100);
      queue_cmd(1, 0, 0, 0, 0, 100);
      queue_cmd(0, 1, 2, 1, 0, 100);
      queue_cmd(1, 0, 0, 0, 0, 100);
      queue_cmd(0, 4, 0, 0, 1, 100);
      queue_cmd(0, 4, 1, 1, 1, 101);
      queue_cmd(1, 0, 0, 0, 0, 101);
      queue_cmd(0, 4, 7, 0, 1, 101);
      queue_cmd(1, 0, 0, 0, 0, 101);
      queue_cmd(1, 0, 0, 0, 0, 32'hFFFF_FFFF);
      wait_idle();

      // long timeouts, default ranks
      write_reg(CSR_TMO_LOW, 64'h0100_0080_0040_0020);
      write_reg(CSR_TMO_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
      clk_now = 32'hFFFF_FF00;
      random_phase(150);

      // equal ranks, all enabled, maximal timeouts
      write_reg(CSR_ENABLE, 64'hFF);
      write_reg(CSR_RANKS, 64'h000000);
      write_reg(CSR_TMO_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
      random_phase(150);

      // partial enable, top ranks, short timeouts
      write_reg(CSR_ENABLE, 64'hA5);
      write_reg(CSR_RANKS, 64'hFFFFFF);
      write_reg(CSR_TMO_LOW, 64'h0003_0010_0000_0040);
      random_phase(120);

      // nothing enabled, then random settings
      write_reg(CSR_ENABLE, 64'h00);
      write_reg(CSR_TMO_HIGH, 64'h0);
      random_phase(30);
      write_reg(CSR_ENABLE, 64'($urandom | 32'h0F));
      write_reg(CSR_RANKS, 64'($urandom));
      write_reg(CSR_TMO_LOW, {$urandom_range(0, 255), $urandom_range(0, 255)} * 64'h1_0001);
      random_phase(150);

      $display("covered %0d responses, %0d accepted samples, %0d selection changes",
               n_rsp, n_acc, n_changes);
      if (errors == 0)
         $display("tb_command_source_priority_arbiter: PASS");
      else
         $display("tb_command_source_priority_arbiter: FAIL");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_command_source_priority_arbiter: FAIL");
      $finish;
   end
endmodule
